// ===== design/cqe_pkg.sv =====
// shared types and constants for the circular queue engine
package cqe_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SHOW = 2'd2,
    OP_PEEK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [DATA_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    op_e                       op;
    logic                      writes;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage

// ===== design/cqe_front.sv =====
// input register and command decode
module cqe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cqe_pkg::in_item_t in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_full_i,
  output cqe_pkg::cmd_t     cmd_o
);
  import cqe_pkg::*;

  logic  valid_q;
  cmd_t  cmd_q;
  cmd_t  cmd_d;
  logic  push;
  logic  load;

  assign push       = valid_q && !cmd_full_i;
  assign in_stall_o = valid_q && cmd_full_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_d.op     = in_i.operation;
    cmd_d.writes = (in_i.operation == OP_ENQ);
    cmd_d.value  = (in_i.operation == OP_ENQ) ? in_i.push_value : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (push) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== design/cqe_cmd_fifo.sv =====
// two-entry command queue between front and back
module cqe_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cqe_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cqe_pkg::cmd_t cmd_o
);
  import cqe_pkg::*;

  cmd_t        entry_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_push;
  logic        do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/cqe_back.sv =====
// ring buffer storage, pointer update and result register
module cqe_back #(
  parameter int unsigned DEPTH = cqe_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cqe_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cqe_pkg::out_item_t out_o
);
  import cqe_pkg::*;

  localparam int unsigned AW       = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_q;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic          holds_q, holds_d;
  logic          busy_q, busy_d;
  logic [AW-1:0] pos_q, pos_d;

  logic          out_valid_q;
  status_e       status_q, status_d;
  logic          last_q, last_d;
  logic          use_mem_q, use_mem_d;

  logic          fire;
  logic          pop;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] tail_nx;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  assign fire    = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign tail_nx = next_pos(tail_q);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    holds_d   = holds_q;
    busy_d    = busy_q;
    pos_d     = pos_q;
    pop       = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = tail_nx;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    status_d  = ST_OK;
    last_d    = 1'b1;
    use_mem_d = 1'b0;
    if (cmd_i.writes) begin
      if (!holds_q) begin
        head_d  = '0;
        tail_d  = '0;
        holds_d = 1'b1;
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (tail_nx == head_q) begin
        status_d = ST_FULL;
      end else begin
        tail_d = tail_nx;
        wr_en  = 1'b1;
      end
    end else if (!holds_q) begin
      status_d = ST_EMPTY;
    end else begin
      case (cmd_i.op)
        OP_DEQ: begin
          rd_en     = 1'b1;
          use_mem_d = 1'b1;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            holds_d = 1'b0;
          end else begin
            head_d = next_pos(head_q);
          end
        end
        OP_SHOW: begin
          rd_en     = 1'b1;
          use_mem_d = 1'b1;
          rd_addr   = busy_q ? pos_q : head_q;
          last_d    = (rd_addr == tail_q);
          if (last_d) begin
            busy_d = 1'b0;
          end else begin
            pop    = 1'b0;
            busy_d = 1'b1;
            pos_d  = next_pos(rd_addr);
          end
        end
        OP_PEEK: begin
          rd_en     = 1'b1;
          use_mem_d = 1'b1;
        end
        default: begin
          status_d = ST_EMPTY;
        end
      endcase
    end
  end

  assign cmd_pop_o = fire && pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      holds_q     <= 1'b0;
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      last_q      <= 1'b0;
      use_mem_q   <= 1'b0;
    end else if (fire) begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      holds_q     <= holds_d;
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= 1'b1;
      status_q    <= status_d;
      last_q      <= last_d;
      use_mem_q   <= use_mem_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    if (fire && rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_o.status = status_q;
  assign out_o.data   = use_mem_q ? rd_q : '0;
  assign out_o.last   = last_q;

endmodule

// ===== design/circular_queue_engine.sv =====
// top level of the circular queue engine
// usage:
//   input channel in_valid_i / in_stall_o / in_i carries one operation per
//   transaction: enqueue, dequeue, display or peek, with the word to store.
//   output channel out_valid_o / out_stall_i / out_o carries the results:
//   status, data and last. every operation gives one result with last set,
//   except display, which gives one result per stored word, oldest first.
// path: a transaction accepted at the input passes the input register, the
//   command queue, execute and the result register before its result leaves.
// throughput: enqueue, dequeue and peek sustain one transaction per cycle when
//   nothing stalls; display holds the execute stage until every stored word is
//   read, as the single read port of the word store delivers one word per cycle.
// reset: the queue comes up empty; stored words are not cleared and no
//   clearing pass is needed.
// receiver stall: the result register holds its transaction, the execute
//   stage waits, the command queue fills and in_stall_o then rises.
module circular_queue_engine #(
  parameter int unsigned DEPTH = cqe_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cqe_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cqe_pkg::out_item_t out_o
);
  import cqe_pkg::*;

  logic fr_valid;
  cmd_t fr_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  cqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cmd_valid_o (fr_valid),
    .cmd_full_i  (q_full),
    .cmd_o       (fr_cmd)
  );

  cqe_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fr_valid),
    .push_cmd_i (fr_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  cqe_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != ST_OK) |-> out_o.last)
    else $error("error status without last");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != ST_OK) |-> (out_o.data == '0))
    else $error("error status with nonzero data");

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  a_no_status_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.status == ST_OK || out_o.status == ST_FULL ||
                     out_o.status == ST_EMPTY))
    else $error("undefined status code");

endmodule

// ===== tb/tb_circular_queue_engine.sv =====
// self-checking testbench for the circular queue engine: ring predictor and result scoreboard
module tb_circular_queue_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import cqe_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;
  localparam int unsigned IDX_W  = $clog2(QDEPTH);
  localparam int unsigned CALM_TAIL = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  circular_queue_engine #(.DEPTH(QDEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // predicted ring contents
  logic signed [DATA_W-1:0] ring_words [QDEPTH];
  logic [IDX_W-1:0]         oldest_idx = '0;
  logic [IDX_W-1:0]         newest_idx = '0;
  logic                     ring_loaded = 1'b0;

  in_item_t  pending_ops[$];
  out_item_t awaited_results[$];
  out_item_t want;
  int        total_ops;
  int        accepted_count = 0;
  int        mismatch_count = 0;
  int        in_idle_left = 0;
  int        out_idle_left = 0;
  bit        in_jittery = 1'b1;
  bit        out_jittery = 1'b1;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QDEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic void predict_results(input in_item_t item);
    out_item_t        r;
    int unsigned      span;
    logic [IDX_W-1:0] p;
    r.status = ST_OK;
    r.data   = '0;
    r.last   = 1'b1;
    if (item.operation == OP_ENQ) begin
      if (!ring_loaded) begin
        oldest_idx = '0;
        newest_idx = '0;
        ring_words[0] = item.push_value;
        ring_loaded = 1'b1;
      end else if (ring_next(newest_idx) == oldest_idx) begin
        r.status = ST_FULL;
      end else begin
        newest_idx = ring_next(newest_idx);
        ring_words[newest_idx] = item.push_value;
      end
      awaited_results.push_back(r);
    end else if (!ring_loaded) begin
      r.status = ST_EMPTY;
      awaited_results.push_back(r);
    end else if (item.operation == OP_DEQ) begin
      r.data = ring_words[oldest_idx];
      if (oldest_idx == newest_idx) begin
        oldest_idx = '0;
        newest_idx = '0;
        ring_loaded = 1'b0;
      end else begin
        oldest_idx = ring_next(oldest_idx);
      end
      awaited_results.push_back(r);
    end else if (item.operation == OP_PEEK) begin
      r.data = ring_words[oldest_idx];
      awaited_results.push_back(r);
    end else begin
      span = ((int'(newest_idx) + QDEPTH - int'(oldest_idx)) % QDEPTH) + 1;
      p = oldest_idx;
      for (int unsigned k = 0; k < span; k++) begin
        r.data = ring_words[p];
        r.last = (k + 1 == span);
        awaited_results.push_back(r);
        p = ring_next(p);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_op(input op_e op, input logic [DATA_W-1:0] v);
    in_item_t it;
    it.operation  = op;
    it.push_value = v;
    pending_ops.push_back(it);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) begin
          predict_results(in_i);
          accepted_count++;
        end
        if (in_idle_left > 0) begin
          in_idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > CALM_TAIL && in_jittery &&
                     $urandom_range(0, 3) == 0) begin
          in_idle_left = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_valid_i <= 1'b1;
          in_i       <= pending_ops.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if ($urandom_range(0, 39) == 0) in_jittery = !in_jittery;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction: status %0d data %0d last %0b",
                                    out_o.status, out_o.data, out_o.last));
        end else begin
          want = awaited_results.pop_front();
          if (out_o.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_o.status, want.status));
          if (out_o.data !== want.data)
            report_mismatch($sformatf("data got %0d want %0d", out_o.data, want.data));
          if (out_o.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_o.last, want.last));
        end
      end
      if (out_idle_left > 0) begin
        out_idle_left--;
        out_stall_i <= 1'b1;
      end else if (pending_ops.size() > CALM_TAIL && out_jittery &&
                   $urandom_range(0, 3) == 0) begin
        out_idle_left = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if ($urandom_range(0, 39) == 0) out_jittery = !out_jittery;
    end
  end

  initial begin
    int  lean;
    int  enq_pct;
    op_e op;
    // empty queue cases
    queue_op(OP_PEEK, $urandom());
    queue_op(OP_DEQ,  $urandom());
    queue_op(OP_SHOW, $urandom());
    // dequeue of the only word
    queue_op(OP_ENQ,  32'h8000_0000);
    queue_op(OP_DEQ,  32'h7fff_ffff);
    // fill to the brim, then overflow
    queue_op(OP_ENQ,  32'h7fff_ffff);
    queue_op(OP_ENQ,  32'hffff_ffff);
    queue_op(OP_ENQ,  32'h0000_0000);
    queue_op(OP_ENQ,  32'h5555_5555);
    queue_op(OP_ENQ,  32'haaaa_aaaa);
    queue_op(OP_ENQ,  32'h0000_0001);
    queue_op(OP_ENQ,  32'h1234_5678);
    queue_op(OP_ENQ,  32'hdead_beef);
    queue_op(OP_ENQ,  32'h0000_0005);
    queue_op(OP_SHOW, 32'hffff_ffff);
    queue_op(OP_PEEK, 32'h0000_0000);
    queue_op(OP_DEQ,  32'h0);
    queue_op(OP_DEQ,  32'h0);
    // wrap around the ring
    queue_op(OP_ENQ,  32'h0f0f_0f0f);
    queue_op(OP_ENQ,  32'hf0f0_f0f0);
    queue_op(OP_SHOW, 32'h0);
    queue_op(OP_PEEK, 32'h0);
    // random phases leaning towards filling, draining or neither
    for (int n = 0; n < 140; n++) begin
      if (n % 20 == 0) lean = $urandom_range(0, 2);
      enq_pct = (lean == 0) ? 70 : (lean == 1) ? 25 : 50;
      if ($urandom_range(0, 99) < enq_pct) begin
        op = OP_ENQ;
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    op = OP_DEQ;
          2:       op = OP_PEEK;
          default: op = OP_SHOW;
        endcase
      end
      queue_op(op, pick_word());
    end
    total_ops = pending_ops.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_ops || awaited_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
